FILE: src/lcgx_pkg.sv
// ---------------------------------------------------------------------------
// lcgx_pkg
// Shared types and constants for the LCG keystream XOR cipher.
// ---------------------------------------------------------------------------
package lcgx_pkg;

   localparam int KEY_W          = 31;
   localparam int DATA_W         = 8;
   localparam int SUM_W          = 2 * KEY_W;
   localparam int CSR_IDX_W      = 2;
   localparam int WORD_BYTES_DEF = 4;
   localparam int WORD_BYTES_MAX = 8;
   localparam int Q_DEPTH        = 2;

   localparam logic [KEY_W-1:0] MULTIPLIER_RST = KEY_W'(1103515245);
   localparam logic [KEY_W-1:0] INCREMENT_RST  = KEY_W'(12345);
   localparam logic [KEY_W-1:0] MODULUS_RST    = KEY_W'(2147483647);
   localparam logic [KEY_W-1:0] SEED_RST       = KEY_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MULTIPLIER = 2'd0,
      CSR_INCREMENT  = 2'd1,
      CSR_MODULUS    = 2'd2,
      CSR_SEED       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic [KEY_W-1:0] multiplier;
      logic [KEY_W-1:0] increment;
      logic [KEY_W-1:0] modulus;
   } lcg_cfg_type;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] prev;
   } next_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [KEY_W-1:0] word;
   } next_rsp_type;

endpackage

FILE: src/lcgx_front.sv
// ---------------------------------------------------------------------------
// lcgx_front
// Input side: takes request words into a short queue for the back end.
// ---------------------------------------------------------------------------
module lcgx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcgx_pkg::item_type req_item,
   output logic              q_valid,
   output lcgx_pkg::item_type q_item,
   input  logic              q_pop
);
   import lcgx_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   item_type           entries_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign req_ready = (count_ff != CNT_W'(Q_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = entries_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

FILE: src/lcgx_next_word.sv
// ---------------------------------------------------------------------------
// lcgx_next_word
// Next key word: (a * x + c) mod m by multiply, add and radix-2 remainder.
// ---------------------------------------------------------------------------
module lcgx_next_word (
   input  logic                  clock,
   input  logic                  reset,
   input  lcgx_pkg::lcg_cfg_type cfg,
   input  lcgx_pkg::next_req_type req,
   output lcgx_pkg::next_rsp_type rsp
);
   import lcgx_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   typedef enum logic [1:0] {
      NW_IDLE,
      NW_MUL,
      NW_ADD,
      NW_REDUCE
   } nw_state_type;

   nw_state_type       state_ff;
   logic               done_ff;
   logic [KEY_W-1:0]   a_ff, x_ff, c_ff, m_ff;
   logic [SUM_W-1:0]   prod_ff, sum_ff;
   logic [KEY_W-1:0]   rem_ff, word_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [KEY_W:0]     trial;
   logic [KEY_W-1:0]   rem_next;

   // one restoring step: shift in next dividend bit, subtract if it fits
   assign trial = {rem_ff, sum_ff[SUM_W-1]};
   always_comb begin
      if (trial >= {1'b0, m_ff}) begin
         rem_next = KEY_W'(trial - {1'b0, m_ff});
      end else begin
         rem_next = KEY_W'(trial);
      end
   end

   assign rsp.busy = (state_ff != NW_IDLE) || done_ff;
   assign rsp.done = done_ff;
   assign rsp.word = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NW_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            NW_IDLE: begin
               done_ff <= 1'b0;
               if (req.start) begin
                  a_ff     <= cfg.multiplier;
                  c_ff     <= cfg.increment;
                  m_ff     <= cfg.modulus;
                  x_ff     <= req.prev;
                  state_ff <= NW_MUL;
               end
            end
            NW_MUL: begin
               prod_ff  <= SUM_W'(a_ff) * SUM_W'(x_ff);
               state_ff <= NW_ADD;
            end
            NW_ADD: begin
               sum_ff   <= prod_ff + SUM_W'(c_ff);
               rem_ff   <= '0;
               cnt_ff   <= CNT_W'(SUM_W - 1);
               state_ff <= NW_REDUCE;
            end
            NW_REDUCE: begin
               if (m_ff == '0) begin
                  // zero modulus: plain truncation
                  word_ff  <= sum_ff[KEY_W-1:0];
                  done_ff  <= 1'b1;
                  state_ff <= NW_IDLE;
               end else begin
                  rem_ff <= rem_next;
                  sum_ff <= sum_ff << 1;
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == '0) begin
                     word_ff  <= rem_next;
                     done_ff  <= 1'b1;
                     state_ff <= NW_IDLE;
                  end
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= NW_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/lcgx_back.sv
// ---------------------------------------------------------------------------
// lcgx_back
// Back end: XORs queued words with the keystream, steps the generator.
// ---------------------------------------------------------------------------
module lcgx_back #(
   parameter int WORD_BYTES = lcgx_pkg::WORD_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  lcgx_pkg::item_type           q_item,
   output logic                         q_pop,
   input  logic [lcgx_pkg::KEY_W-1:0]   seed_word,
   output lcgx_pkg::next_req_type       nw_req,
   input  lcgx_pkg::next_rsp_type       nw_rsp,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lcgx_pkg::DATA_W-1:0]  rsp_out_byte,
   output logic                         rsp_out_last
);
   import lcgx_pkg::*;

   localparam int POS_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
   localparam int EXT_W = 8 * WORD_BYTES_MAX;

   logic [KEY_W-1:0]  key_word_ff, key_word_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              at_start_ff, at_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] out_byte_ff;
   logic              out_last_ff;
   logic [KEY_W-1:0]  word;
   logic [EXT_W-1:0]  word_shift;
   logic [DATA_W-1:0] key_byte;
   logic              wrap;

   assign word       = at_start_ff ? seed_word : key_word_ff;
   // bytes above the key word read as zero
   assign word_shift = {{(EXT_W - KEY_W){1'b0}}, word} >> {pos_ff, 3'b000};
   assign key_byte   = word_shift[DATA_W-1:0];
   assign wrap       = (pos_ff == POS_W'(WORD_BYTES - 1));

   // hold off while the next key word is still being formed
   assign q_pop = q_valid && !nw_rsp.busy && (!rsp_valid_ff || rsp_ready);

   assign nw_req.start = q_pop && !q_item.last_byte && wrap;
   assign nw_req.prev  = word;

   always_comb begin
      key_word_in  = key_word_ff;
      pos_in       = pos_ff;
      at_start_in  = at_start_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (nw_rsp.done) begin
         key_word_in = nw_rsp.word;
      end
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         if (q_item.last_byte) begin
            at_start_in = 1'b1;
            pos_in      = '0;
         end else begin
            at_start_in = 1'b0;
            key_word_in = word;
            pos_in      = wrap ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         at_start_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         at_start_ff  <= at_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_word_ff <= key_word_in;
      if (q_pop) begin
         out_byte_ff <= q_item.data_byte ^ key_byte;
         out_last_ff <= q_item.last_byte;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

endmodule

FILE: src/lcg_keystream_xor_cipher.sv
// ---------------------------------------------------------------------------
// lcg_keystream_xor_cipher
// Byte stream XOR with an LCG keystream; same block encrypts and decrypts.
// ---------------------------------------------------------------------------
//  channel | ports                                    | direction
//  req     | req_valid/req_ready, data_byte, last_byte | in
//  rsp     | rsp_valid/rsp_ready, out_byte, out_last   | out
//  csr     | csr_wr_en, csr_index, csr_wdata           | in, write only
//
// One word per cycle while a key word is on hand and rsp is not stalled. Every
// WORD_BYTES-th word that does not end a message starts the next key word in
// the remainder unit: 1 multiply, 1 add and 62 shift-subtract steps (none at
// zero modulus); the back end holds until that key word is done.
// Synchronous reset loads the register defaults and restarts from the seed.
// A two-word queue and an output register let req and rsp stall separately.
// ---------------------------------------------------------------------------
module lcg_keystream_xor_cipher #(
   parameter int WORD_BYTES = lcgx_pkg::WORD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lcgx_pkg::DATA_W-1:0]     req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lcgx_pkg::DATA_W-1:0]     rsp_out_byte,
   output logic                            rsp_out_last,
   input  logic                            csr_wr_en,
   input  logic [lcgx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcgx_pkg::KEY_W-1:0]      csr_wdata
);
   import lcgx_pkg::*;

   logic [KEY_W-1:0] multiplier_ff, increment_ff, modulus_ff, seed_word_ff;
   item_type         req_item, q_item;
   logic             q_valid, q_pop;
   lcg_cfg_type      cfg;
   next_req_type     nw_req;
   next_rsp_type     nw_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= MULTIPLIER_RST;
         increment_ff  <= INCREMENT_RST;
         modulus_ff    <= MODULUS_RST;
         seed_word_ff  <= SEED_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MULTIPLIER: multiplier_ff <= csr_wdata;
            CSR_INCREMENT:  increment_ff  <= csr_wdata;
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            CSR_SEED:       seed_word_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.multiplier = multiplier_ff;
   assign cfg.increment  = increment_ff;
   assign cfg.modulus    = modulus_ff;

   assign req_item.data_byte = req_data_byte;
   assign req_item.last_byte = req_last_byte;

   lcgx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   lcgx_next_word u_next_word (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (nw_req),
      .rsp   (nw_rsp)
   );

   lcgx_back #(
      .WORD_BYTES (WORD_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .seed_word    (seed_word_ff),
      .nw_req       (nw_req),
      .nw_rsp       (nw_rsp),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: dv/lcgx_cipher_checker.sv
// ---------------------------------------------------------------------------
// lcgx_cipher_checker
// Watches the req, rsp and csr ports of the LCG keystream XOR cipher, keeps
// its own keystream generator and compares every returned word in order.
// ---------------------------------------------------------------------------
module lcgx_cipher_checker #(
   parameter int WORD_BYTES = lcgx_pkg::WORD_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [lcgx_pkg::DATA_W-1:0]    req_data_byte,
   input  logic                           req_last_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [lcgx_pkg::DATA_W-1:0]    rsp_out_byte,
   input  logic                           rsp_out_last,
   input  logic                           csr_wr_en,
   input  logic [lcgx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcgx_pkg::KEY_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   import lcgx_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              out_last;
   } cipher_word_type;

   cipher_word_type  expected_words[$];

   logic [KEY_W-1:0] lcg_mult;
   logic [KEY_W-1:0] lcg_inc;
   logic [KEY_W-1:0] lcg_mod;
   logic [KEY_W-1:0] lcg_seed;
   logic [KEY_W-1:0] key_word;
   int               byte_pos;
   logic             msg_start;
   int               mismatches = 0;

   // next key word; modulus zero means plain 31-bit wrap
   function automatic logic [KEY_W-1:0] lcg_advance(input logic [KEY_W-1:0] prev);
      logic [63:0] sum;
      sum = 64'(lcg_mult) * 64'(prev) + 64'(lcg_inc);
      if (lcg_mod == '0) begin
         return sum[KEY_W-1:0];
      end
      return KEY_W'(sum % 64'(lcg_mod));
   endfunction

   task automatic cipher_step(input logic [DATA_W-1:0] data, input logic last);
      logic [KEY_W-1:0] cur_word;
      logic [31:0]      shifted;
      cipher_word_type  exp_word;
      cur_word = msg_start ? lcg_seed : key_word;
      shifted  = {1'b0, cur_word} >> (8 * byte_pos);
      exp_word.out_byte = data ^ shifted[DATA_W-1:0];
      exp_word.out_last = last;
      expected_words.insert(expected_words.size(), exp_word);
      if (last) begin
         msg_start = 1'b1;
         byte_pos  = 0;
         key_word  = lcg_seed;
      end else begin
         key_word  = cur_word;
         msg_start = 1'b0;
         byte_pos++;
         if (byte_pos >= WORD_BYTES) begin
            byte_pos = 0;
            key_word = lcg_advance(cur_word);
         end
      end
   endtask

   task automatic compare_word(input logic [DATA_W-1:0] got_byte, input logic got_last);
      cipher_word_type exp_word;
      if (expected_words.size() == 0) begin
         $display("%0t: word with none pending, out_byte %02h out_last %0b",
                  $time, got_byte, got_last);
         mismatches++;
      end else begin
         exp_word = expected_words.pop_front();
         if (got_byte !== exp_word.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, exp_word.out_byte, got_byte);
            mismatches++;
         end
         if (got_last !== exp_word.out_last) begin
            $display("%0t: out_last expected %0b actual %0b",
                     $time, exp_word.out_last, got_last);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lcg_mult  = MULTIPLIER_RST;
         lcg_inc   = INCREMENT_RST;
         lcg_mod   = MODULUS_RST;
         lcg_seed  = SEED_RST;
         key_word  = SEED_RST;
         byte_pos  = 0;
         msg_start = 1'b1;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_MULTIPLIER: lcg_mult = csr_wdata;
               CSR_INCREMENT:  lcg_inc  = csr_wdata;
               CSR_MODULUS:    lcg_mod  = csr_wdata;
               CSR_SEED:       lcg_seed = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            cipher_step(req_data_byte, req_last_byte);
         end
         if (rsp_valid && rsp_ready) begin
            compare_word(rsp_out_byte, rsp_out_last);
         end
      end
      // nonblocking so the stimulus side reads settled values at the edge
      outstanding <= expected_words.size();
      fail_count  <= mismatches;
   end

endmodule

FILE: dv/tb_lcg_keystream_xor_cipher.sv
// ---------------------------------------------------------------------------
// tb_lcg_keystream_xor_cipher
// Drives message bytes and register writes into the LCG keystream cipher
// under varying back pressure; the checker predicts each output word.
// ---------------------------------------------------------------------------
module tb_lcg_keystream_xor_cipher;

   timeunit 1ns;
   timeprecision 1ps;

   import lcgx_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int SEG_WORDS     = 100;
   localparam int SEGMENTS      = 5;
   localparam int CYCLE_LIMIT   = 400000;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [DATA_W-1:0]    req_data_byte = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [DATA_W-1:0]    rsp_out_byte;
   logic                 rsp_out_last;
   logic                 csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_MULTIPLIER;
   logic [KEY_W-1:0]     csr_wdata     = '0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int msg_left      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lcg_keystream_xor_cipher u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   lcgx_cipher_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(input logic [DATA_W-1:0] data, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_message(input int len, input logic terminate);
      for (int i = 0; i < len; i++) begin
         send_word(DATA_W'($urandom_range(0, 255)), terminate && (i == len - 1));
      end
   endtask

   // stop sending, let every word come back and the key unit go quiet
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [KEY_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_lcg(input logic [3:0] sel, input logic [KEY_W-1:0] mult,
                              input logic [KEY_W-1:0] inc, input logic [KEY_W-1:0] modulus,
                              input logic [KEY_W-1:0] seed);
      if (sel[CSR_MULTIPLIER]) csr_write(CSR_MULTIPLIER, mult);
      if (sel[CSR_INCREMENT])  csr_write(CSR_INCREMENT, inc);
      if (sel[CSR_MODULUS])    csr_write(CSR_MODULUS, modulus);
      if (sel[CSR_SEED])       csr_write(CSR_SEED, seed);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_reg();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return KEY_W'($urandom_range(1, 16));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 8);
      if (r < 9) return $urandom_range(9, 24);
      return $urandom_range(25, 64);
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings; message runs past the first key word
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'h80, 1'b1);
      send_word(8'hFF, 1'b1);

      // top values, modulus zero: no reduction
      quiesce();
      program_lcg(4'b1111, '1, '1, '0, '1);
      send_message(5, 1'b1);

      // bottom values, seed above modulus
      quiesce();
      program_lcg(4'b1111, '0, '0, KEY_W'(1), KEY_W'(1000));
      send_message(5, 1'b1);

      // registers change mid-message; new seed only on the next message
      send_message(3, 1'b0);
      quiesce();
      program_lcg(4'b1111, KEY_W'(3), KEY_W'(5), KEY_W'(7), KEY_W'(99));
      send_message(4, 1'b1);
      send_word(8'h3C, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 14; recv_idle_pct = 76; end
            1: begin send_idle_pct = 76; recv_idle_pct = 14; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            program_lcg(4'($urandom_range(1, 15)), pick_reg(), pick_reg(), pick_reg(),
                        pick_reg());
            // a message may span segments, so some writes land mid-message
            for (int n = 0; n < SEG_WORDS; n++) begin
               if (msg_left == 0) msg_left = pick_len();
               send_word(DATA_W'($urandom_range(0, 255)), msg_left == 1);
               msg_left--;
            end
         end
      end

      quiesce();
      if (fail_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/lcgx_pkg.sv
src/lcgx_front.sv
src/lcgx_next_word.sv
src/lcgx_back.sv
src/lcg_keystream_xor_cipher.sv
dv/lcgx_cipher_checker.sv
dv/tb_lcg_keystream_xor_cipher.sv
